[sv/kss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package kss_pkg;

  // Fixed field widths of the item formats.
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned D_W      = 17;
  localparam int unsigned CNT_W    = 9;

  // Default store depths.
  localparam int unsigned WINDOW_DEPTH_DEF    = 256;
  localparam int unsigned REFERENCE_DEPTH_DEF = 256;

  // Command codes.
  localparam logic [1:0] CMD_PUSH_W  = 2'd0;
  localparam logic [1:0] CMD_PUSH_R  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;
  localparam logic [1:0] CMD_CLR_REF = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW = 2'd1;
  localparam logic [1:0] STAT_EMPTY    = 2'd2;

  // Flipping the sign bit makes unsigned order equal signed order.
  localparam logic [SAMPLE_W-1:0] KEY_FLIP = 32'h8000_0000;

  typedef struct packed {
    logic [1:0]                 command;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [D_W-1:0]   d_stat;
    logic [CNT_W-1:0] window_count;
    logic [CNT_W-1:0] reference_count;
    logic [1:0]       status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ins_begin;
    logic ins_step;
    logic clr_ref;
    logic merge_begin;
    logic merge_step;
    logic div_begin;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic push_full;
    logic ins_done;
    logic any_empty;
    logic merge_last;
    logic pipe_busy;
    logic div_last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

[sv/kss_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module kss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

[sv/kss_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module kss_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        in_command_i,
  output logic                   in_stall_o,
  output kss_pkg::dp_cmd_t       cmd_o,
  input  wire kss_pkg::dp_stat_t stat_i
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INS   = 3'd1;
  localparam logic [2:0] ST_MERGE = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_RES   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Sequencer for insertion, reference clear, merge, division and result hand-off.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_command_i inside {kss_pkg::CMD_PUSH_W, kss_pkg::CMD_PUSH_R}) begin
            cmd_o.ins_begin = 1'b1;
            if (!stat_i.push_full) begin
              state_d = ST_INS;
            end
          end else if (in_command_i == kss_pkg::CMD_COMPUTE) begin
            if (stat_i.any_empty) begin
              state_d = ST_RES;
            end else begin
              cmd_o.merge_begin = 1'b1;
              state_d           = ST_MERGE;
            end
          end else begin
            cmd_o.clr_ref = 1'b1;
          end
        end
      end
      ST_INS: begin
        cmd_o.ins_step = 1'b1;
        if (stat_i.ins_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_MERGE: begin
        cmd_o.merge_step = 1'b1;
        if (stat_i.merge_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          cmd_o.div_begin = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_RES;
        end
      end
      ST_RES: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

[sv/kss_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module kss_dp #(
  parameter int unsigned WINDOW_DEPTH    = kss_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned REFERENCE_DEPTH = kss_pkg::REFERENCE_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire kss_pkg::in_item_t  in_item_i,
  input  wire kss_pkg::dp_cmd_t   cmd_i,
  output kss_pkg::dp_stat_t       stat_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output kss_pkg::out_item_t      out_item_o
);

  localparam int unsigned WCW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned RCW = $clog2(REFERENCE_DEPTH + 1);
  localparam int unsigned CW  = (WCW > RCW) ? WCW : RCW;
  localparam int unsigned WAW = $clog2(WINDOW_DEPTH);
  localparam int unsigned RAW = $clog2(REFERENCE_DEPTH);
  localparam int unsigned PW  = WCW + RCW;
  localparam int unsigned KW  = kss_pkg::SAMPLE_W;
  localparam int unsigned DW  = kss_pkg::D_W;
  localparam int unsigned BCW = $clog2(DW);

  logic [WCW-1:0] wfill_q, j1_q, j1_d;
  logic [RCW-1:0] rfill_q, j2_q, j2_d;
  logic           ovf_q;
  logic [KW-1:0]  key_q;
  logic           sel_ref_q;
  logic [CW-1:0]  pos_q, fill_sel, raddr;
  logic [PW-1:0]  p_q, q_q, best_q, m_q, gap;
  logic [PW:0]    rem_q, rem_sub, rem_keep;
  logic           rem_ge;
  logic [DW-1:0]  quo_q;
  logic [BCW-1:0] bit_q;
  logic           s1_q, s2_q;
  logic [KW-1:0]  wrd, rrd, ins_rd;
  logic           push_ref, wfull, rfull, shift;
  logic           we_w, we_r;
  logic [KW-1:0]  wdata;
  logic           out_valid_q;
  kss_pkg::out_item_t out_q;

  kss_ram #(.WIDTH(KW), .DEPTH(WINDOW_DEPTH)) u_wram (
    .clk_i   (clk_i),
    .we_i    (we_w),
    .waddr_i (pos_q[WAW-1:0]),
    .wdata_i (wdata),
    .raddr_i (cmd_i.merge_step ? j1_d[WAW-1:0] : raddr[WAW-1:0]),
    .rdata_o (wrd)
  );

  kss_ram #(.WIDTH(KW), .DEPTH(REFERENCE_DEPTH)) u_rram (
    .clk_i   (clk_i),
    .we_i    (we_r),
    .waddr_i (pos_q[RAW-1:0]),
    .wdata_i (wdata),
    .raddr_i (cmd_i.merge_step ? j2_d[RAW-1:0] : raddr[RAW-1:0]),
    .rdata_o (rrd)
  );

  // Insertion: shift larger entries up one place until the key fits.
  assign push_ref = (in_item_i.command == kss_pkg::CMD_PUSH_R);
  assign wfull    = (wfill_q == WCW'(WINDOW_DEPTH));
  assign rfull    = (rfill_q == RCW'(REFERENCE_DEPTH));
  assign fill_sel = push_ref ? CW'(rfill_q) : CW'(wfill_q);
  assign ins_rd   = sel_ref_q ? rrd : wrd;
  assign shift    = (pos_q != '0) && (ins_rd > key_q);
  assign wdata    = shift ? ins_rd : key_q;
  assign we_w     = cmd_i.ins_step && !sel_ref_q;
  assign we_r     = cmd_i.ins_step && sel_ref_q;

  // Read address for insertion; merge reads start at the first entry.
  always_comb begin
    raddr = '0;
    if (cmd_i.ins_begin) begin
      raddr = fill_sel - CW'(1);
    end else if (cmd_i.ins_step) begin
      raddr = pos_q - CW'(2);
    end
  end

  // Merge step: advance past the smaller head, or both on a tie.
  assign j1_d = j1_q + WCW'(wrd <= rrd);
  assign j2_d = j2_q + RCW'(rrd <= wrd);
  assign gap  = (p_q >= q_q) ? (p_q - q_q) : (q_q - p_q);

  // Restoring division, one quotient bit per cycle.
  assign rem_ge   = (rem_q >= {1'b0, m_q});
  assign rem_sub  = rem_q - {1'b0, m_q};
  assign rem_keep = rem_ge ? rem_sub : rem_q;

  always_comb begin
    stat_o            = '0;
    stat_o.push_full  = push_ref ? rfull : wfull;
    stat_o.ins_done   = !shift;
    stat_o.any_empty  = (wfill_q == '0) || (rfill_q == '0);
    stat_o.merge_last = (j1_d == wfill_q) || (j2_d == rfill_q);
    stat_o.pipe_busy  = s1_q || s2_q;
    stat_o.div_last   = (bit_q == BCW'(DW - 1));
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // Control state: fills, overflow flag, pipeline valids, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wfill_q     <= '0;
      rfill_q     <= '0;
      ovf_q       <= 1'b0;
      s1_q        <= 1'b0;
      s2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.ins_begin && (push_ref ? rfull : wfull)) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.ins_step && !shift) begin
        if (sel_ref_q) begin
          rfill_q <= rfill_q + RCW'(1);
        end else begin
          wfill_q <= wfill_q + WCW'(1);
        end
      end
      if (cmd_i.clr_ref) begin
        rfill_q <= '0;
      end
      s1_q <= cmd_i.merge_step;
      s2_q <= s1_q;
      if (cmd_i.finish) begin
        wfill_q     <= '0;
        ovf_q       <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_begin) begin
      key_q     <= in_item_i.sample ^ kss_pkg::KEY_FLIP;
      sel_ref_q <= push_ref;
      pos_q     <= fill_sel;
    end else if (cmd_i.ins_step && shift) begin
      pos_q <= pos_q - CW'(1);
    end
    if (cmd_i.merge_begin) begin
      j1_q   <= '0;
      j2_q   <= '0;
      best_q <= '0;
      m_q    <= PW'(wfill_q) * PW'(rfill_q);
    end else begin
      if (cmd_i.merge_step) begin
        j1_q <= j1_d;
        j2_q <= j2_d;
      end
      if (s2_q && (gap > best_q)) begin
        best_q <= gap;
      end
    end
    p_q <= PW'(j2_q) * PW'(wfill_q);
    q_q <= PW'(j1_q) * PW'(rfill_q);
    if (cmd_i.div_begin) begin
      rem_q <= {1'b0, best_q};
      quo_q <= '0;
      bit_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= {rem_keep[PW-1:0], 1'b0};
      quo_q <= {quo_q[DW-2:0], rem_ge};
      bit_q <= bit_q + BCW'(1);
    end
    if (cmd_i.finish) begin
      out_q.window_count    <= kss_pkg::CNT_W'(wfill_q);
      out_q.reference_count <= kss_pkg::CNT_W'(rfill_q);
      if (stat_o.any_empty) begin
        out_q.d_stat <= '0;
        out_q.status <= kss_pkg::STAT_EMPTY;
      end else begin
        out_q.d_stat <= quo_q;
        out_q.status <= ovf_q ? kss_pkg::STAT_OVERFLOW : kss_pkg::STAT_OK;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

[sv/ks_two_sample_statistic.sv]
`timescale 1ns / 1ps
`default_nettype none
// Two-sample KS D statistic over a window set and a reference set.
// Input items carry a command and a sample: push to window, push to
// reference, compute (and clear the window), or clear the reference.
// Each set is kept sorted in its own RAM by insertion: a push accepts the
// key, moves each larger entry up one place and then writes the key. A push
// into a full set only records the overflow.
// Compute merges both RAMs one step per cycle, waits for the gap pipeline
// to drain, runs the restoring divider for the 17 quotient bits and loads
// the output register. An empty set skips the merge and the division.
// One item is in work at a time, and in_stall_o is high while it is.
// A result waits in the output register while out_stall_i is high; new
// pushes are still taken, and only the next result waits for it.
// Reset empties both sets, clears the overflow flag and the output valid;
// RAM contents are not cleared.
module ks_two_sample_statistic #(
  parameter int unsigned WINDOW_DEPTH    = kss_pkg::WINDOW_DEPTH_DEF,
  parameter int unsigned REFERENCE_DEPTH = kss_pkg::REFERENCE_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire kss_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output kss_pkg::out_item_t      out_item_o
);

  kss_pkg::dp_cmd_t  cmd;
  kss_pkg::dp_stat_t stat;

  // Sequencer.
  kss_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_item_i.command),
    .in_stall_o   (in_stall_o),
    .cmd_o        (cmd),
    .stat_i       (stat)
  );

  // Stores, merge, divider and output register.
  kss_dp #(
    .WINDOW_DEPTH    (WINDOW_DEPTH),
    .REFERENCE_DEPTH (REFERENCE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

[test/tb_ks_two_sample_statistic.sv]
`timescale 1ns / 1ps
module tb_ks_two_sample_statistic;

  localparam int unsigned DEPTH = kss_pkg::WINDOW_DEPTH_DEF;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  kss_pkg::in_item_t  in_item_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  kss_pkg::out_item_t out_item_o;

  // Idling is switched off during the quiet stretch.
  bit quiet = 1'b0;
  int errors = 0;

  // Predicted state: sorted keys (sign bit flipped) and fills.
  logic [kss_pkg::SAMPLE_W-1:0] win_keys [DEPTH];
  logic [kss_pkg::SAMPLE_W-1:0] ref_keys [DEPTH];
  int unsigned                  win_fill = 0;
  int unsigned                  ref_fill = 0;
  bit                           dropped = 1'b0;
  kss_pkg::out_item_t           pending_stats [$];

  ks_two_sample_statistic dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Insert one key in sorted order; equal keys stay in arrival order.
  task automatic insert_key(bit to_ref, logic [kss_pkg::SAMPLE_W-1:0] key);
    int unsigned pos;
    pos = to_ref ? ref_fill : win_fill;
    if (pos >= DEPTH) begin
      dropped = 1'b1;
    end else if (to_ref) begin
      while (pos > 0 && ref_keys[pos-1] > key) begin
        ref_keys[pos] = ref_keys[pos-1];
        pos--;
      end
      ref_keys[pos] = key;
      ref_fill++;
    end else begin
      while (pos > 0 && win_keys[pos-1] > key) begin
        win_keys[pos] = win_keys[pos-1];
        pos--;
      end
      win_keys[pos] = key;
      win_fill++;
    end
  endtask

  // Apply one accepted item to the predicted state and queue any result.
  task automatic predict_stat(kss_pkg::in_item_t it);
    logic [kss_pkg::SAMPLE_W-1:0] key;
    longint unsigned n1, n2, j1, j2, p, q, gap, best, d;
    kss_pkg::out_item_t r;
    key = it.sample ^ kss_pkg::KEY_FLIP;
    case (it.command)
      kss_pkg::CMD_PUSH_W:  insert_key(1'b0, key);
      kss_pkg::CMD_PUSH_R:  insert_key(1'b1, key);
      kss_pkg::CMD_CLR_REF: ref_fill = 0;
      default: begin
        n1 = win_fill;
        n2 = ref_fill;
        j1 = 0;
        j2 = 0;
        best = 0;
        r = '0;
        r.window_count = n1[kss_pkg::CNT_W-1:0];
        r.reference_count = n2[kss_pkg::CNT_W-1:0];
        if (n1 == 0 || n2 == 0) begin
          r.status = kss_pkg::STAT_EMPTY;
        end else begin
          while (j1 < n1 && j2 < n2) begin
            logic [kss_pkg::SAMPLE_W-1:0] a, b;
            a = win_keys[j1];
            b = ref_keys[j2];
            if (a <= b) j1++;
            if (b <= a) j2++;
            p = j2 * n1;
            q = j1 * n2;
            gap = (p >= q) ? p - q : q - p;
            if (gap > best) best = gap;
          end
          d = (best << 16) / (n1 * n2);
          r.d_stat = d[kss_pkg::D_W-1:0];
          r.status = dropped ? kss_pkg::STAT_OVERFLOW : kss_pkg::STAT_OK;
        end
        pending_stats.push_back(r);
        win_fill = 0;
        dropped = 1'b0;
      end
    endcase
  endtask

  // Send one item; called at a rising edge, returns at the accepting edge.
  task automatic send_item(logic [1:0] cmd, logic signed [kss_pkg::SAMPLE_W-1:0] value);
    kss_pkg::in_item_t it;
    bit busy;
    it.command = cmd;
    it.sample = value;
    while (!quiet && $urandom_range(99) < 37) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do begin
      @(negedge clk_i);
      busy = in_stall_o;
      @(posedge clk_i);
    end while (busy);
    predict_stat(it);
  endtask

  // Random sample: full range, clustered for ties, or at the extremes.
  function automatic logic signed [kss_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(16)) - 8;
      2: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $signed($urandom_range(2000)) - 1000;
    endcase
  endfunction

  // Pause sending until every predicted result has come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_stats.size() != 0) @(posedge clk_i);
  endtask

  // Extremes of the sample range, ties and fully separated sets.
  task automatic test_edges();
    send_item(kss_pkg::CMD_PUSH_W, 32'sh8000_0000);
    send_item(kss_pkg::CMD_PUSH_W, 32'sh7fff_ffff);
    send_item(kss_pkg::CMD_PUSH_R, 32'sh8000_0000);
    send_item(kss_pkg::CMD_PUSH_R, 32'sh7fff_ffff);
    send_item(kss_pkg::CMD_COMPUTE, 32'sh7fff_ffff);
    // Equal sets with repeated values give zero.
    send_item(kss_pkg::CMD_CLR_REF, $urandom);
    send_item(kss_pkg::CMD_PUSH_W, 5);
    send_item(kss_pkg::CMD_PUSH_W, 5);
    send_item(kss_pkg::CMD_PUSH_R, 5);
    send_item(kss_pkg::CMD_PUSH_R, 5);
    send_item(kss_pkg::CMD_COMPUTE, 0);
    // Disjoint sets give the full-scale value.
    send_item(kss_pkg::CMD_CLR_REF, 0);
    send_item(kss_pkg::CMD_PUSH_W, -1);
    send_item(kss_pkg::CMD_PUSH_W, -3);
    send_item(kss_pkg::CMD_PUSH_R, 0);
    send_item(kss_pkg::CMD_COMPUTE, 0);
  endtask

  // Empty window, empty reference, and an empty window once more.
  task automatic test_empty();
    send_item(kss_pkg::CMD_COMPUTE, 0);
    send_item(kss_pkg::CMD_CLR_REF, 0);
    send_item(kss_pkg::CMD_PUSH_W, 7);
    send_item(kss_pkg::CMD_COMPUTE, 0);
    send_item(kss_pkg::CMD_PUSH_R, 1);
    send_item(kss_pkg::CMD_COMPUTE, 0);
  endtask

  // Fill both stores past capacity; the flag survives a reference clear.
  task automatic test_overflow();
    for (int i = 0; i < DEPTH + 2; i++) send_item(kss_pkg::CMD_PUSH_W, pick_sample());
    send_item(kss_pkg::CMD_CLR_REF, 0);
    send_item(kss_pkg::CMD_COMPUTE, 0);
    for (int i = 0; i < DEPTH + 1; i++) send_item(kss_pkg::CMD_PUSH_R, pick_sample());
    for (int i = 0; i < DEPTH; i++) send_item(kss_pkg::CMD_PUSH_W, pick_sample());
    send_item(kss_pkg::CMD_CLR_REF, 0);
    for (int i = 0; i < 3; i++) send_item(kss_pkg::CMD_PUSH_R, pick_sample());
    send_item(kss_pkg::CMD_COMPUTE, 0);
    send_item(kss_pkg::CMD_PUSH_W, 0);
    send_item(kss_pkg::CMD_COMPUTE, 0);
  endtask

  // Mostly well-formed sequences of small sets, with random noise items.
  task automatic test_random(int unsigned budget);
    int unsigned sent, nw, nr;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(9) == 0) begin
        send_item(2'($urandom_range(3)), $urandom);
        sent++;
      end else begin
        if ($urandom_range(2) == 0) begin
          send_item(kss_pkg::CMD_CLR_REF, $urandom);
          sent++;
        end
        nr = $urandom_range(12);
        nw = $urandom_range(12);
        for (int i = 0; i < nr; i++) send_item(kss_pkg::CMD_PUSH_R, pick_sample());
        for (int i = 0; i < nw; i++) send_item(kss_pkg::CMD_PUSH_W, pick_sample());
        send_item(kss_pkg::CMD_COMPUTE, $urandom);
        sent += nr + nw + 1;
      end
    end
  endtask

  // Result receiver: random stalls, driven at the rising edge.
  always @(posedge clk_i) begin
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 37);
  end

  // Result checker: sample between edges what the next edge accepts.
  always @(negedge clk_i) begin
    kss_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_stats.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item_o);
        errors++;
      end else begin
        want = pending_stats.pop_front();
        if (out_item_o.d_stat !== want.d_stat) begin
          $display("%0t: d_stat expected %0d actual %0d", $time,
                   want.d_stat, out_item_o.d_stat);
          errors++;
        end
        if (out_item_o.window_count !== want.window_count) begin
          $display("%0t: window_count expected %0d actual %0d", $time,
                   want.window_count, out_item_o.window_count);
          errors++;
        end
        if (out_item_o.reference_count !== want.reference_count) begin
          $display("%0t: reference_count expected %0d actual %0d", $time,
                   want.reference_count, out_item_o.reference_count);
          errors++;
        end
        if (out_item_o.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_item_o.status);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edges();
    test_empty();
    test_overflow();
    drain_results();
    test_random(250);
    quiet = 1'b1;
    test_random(200);
    quiet = 1'b0;
    drain_results();
    test_random(300);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (errors == 0 && pending_stats.size() == 0) begin
      $display("[ks_two_sample_statistic] OK");
    end else begin
      $display("[ks_two_sample_statistic] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #80ms;
    $display("[ks_two_sample_statistic] ERROR");
    $finish;
  end

endmodule

[files.f]
sv/kss_pkg.sv
sv/kss_ram.sv
sv/kss_ctrl.sv
sv/kss_dp.sv
sv/ks_two_sample_statistic.sv
test/tb_ks_two_sample_statistic.sv
